// File: rtl/scmd_pkg.sv
// scmd_pkg: shared types, codes and keyword tables of the serial command motor driver.
// Used by scmd_parse and serial_command_motor_driver; depends on nothing.
package scmd_pkg;

	localparam int LINE_CAPACITY = 256;
	localparam int MOTOR_COUNT   = 2;
	localparam int CFG_W         = 10;
	localparam int PULSE_W       = 11;
	localparam int KW_MAX_LEN    = 5;

	// configuration register indexes
	localparam logic [1:0] CFG_STEP_SIZE   = 2'd0;
	localparam logic [1:0] CFG_DUTY_LIMIT  = 2'd1;
	localparam logic [1:0] CFG_CRUISE_DUTY = 2'd2;

	localparam logic [CFG_W-1:0] STEP_SIZE_RST   = 10'd50;
	localparam logic [CFG_W-1:0] DUTY_LIMIT_RST  = 10'd950;
	localparam logic [CFG_W-1:0] CRUISE_DUTY_RST = 10'd500;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ONE   = 8'h31;

	// keyword indexes
	localparam logic [2:0] KW_ON    = 3'd0;
	localparam logic [2:0] KW_OFF   = 3'd1;
	localparam logic [2:0] KW_UP    = 3'd2;
	localparam logic [2:0] KW_DOWN  = 3'd3;
	localparam logic [2:0] KW_STOP  = 3'd4;
	localparam logic [2:0] KW_START = 3'd5;
	localparam logic [2:0] KW_LEFT  = 3'd6;
	localparam logic [2:0] KW_RIGHT = 3'd7;

	// pin pairs, bit 0 = sig1, bit 1 = sig2
	localparam logic [1:0] PINS_BRAKE = 2'b00;
	localparam logic [1:0] PINS_COAST = 2'b11;
	localparam logic [1:0] PINS_FWD   = 2'b01;
	localparam logic [1:0] PINS_REV   = 2'b10;

	typedef enum logic [1:0] {
		PH_BEFORE,
		PH_FIRST,
		PH_AFTER,
		PH_ID
	} phase_t;

	typedef enum logic [3:0] {
		CMD_NONE  = 4'd0,
		CMD_ON    = 4'd1,
		CMD_OFF   = 4'd2,
		CMD_UP    = 4'd3,
		CMD_DOWN  = 4'd4,
		CMD_STOP  = 4'd5,
		CMD_START = 4'd6,
		CMD_LEFT  = 4'd7,
		CMD_RIGHT = 4'd8
	} cmd_t;

	typedef struct packed {
		logic       text_ended;
		logic [7:0] id_char;
		logic       too_long;
		logic [2:0] kw_pos;
		logic [7:0] kw_live;
		phase_t     phase;
	} parse_t;

	localparam parse_t PARSE_CLEAR = '{
		text_ended: 1'b0,
		id_char:    8'h00,
		too_long:   1'b0,
		kw_pos:     3'd0,
		kw_live:    8'hFF,
		phase:      PH_BEFORE
	};

	// keyword text, first character in the top byte, zero padded
	function automatic logic [39:0] kw_text(input logic [2:0] k);
		case (k)
			KW_ON:    return {"on", 24'h0};
			KW_OFF:   return {"off", 16'h0};
			KW_UP:    return {"up", 24'h0};
			KW_DOWN:  return {"down", 8'h0};
			KW_STOP:  return {"stop", 8'h0};
			KW_START: return "start";
			KW_LEFT:  return {"left", 8'h0};
			KW_RIGHT: return "right";
			default:  return 40'h0;
		endcase
	endfunction

	function automatic logic [2:0] kw_len(input logic [2:0] k);
		case (k)
			KW_ON, KW_UP:                return 3'd2;
			KW_OFF:                      return 3'd3;
			KW_DOWN, KW_STOP, KW_LEFT:   return 3'd4;
			KW_START, KW_RIGHT:          return 3'd5;
			default:                     return 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
		logic [39:0] txt;
		txt = kw_text(k);
		case (pos)
			3'd0:    return txt[39:32];
			3'd1:    return txt[31:24];
			3'd2:    return txt[23:16];
			3'd3:    return txt[15:8];
			3'd4:    return txt[7:0];
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic word_is(input parse_t ps, input logic [2:0] k);
		return !ps.too_long && ps.kw_live[k] && (ps.kw_pos == kw_len(k));
	endfunction

endpackage

// File: rtl/scmd_parse.sv
// scmd_parse: token tracker, next parse state for one line byte.
// Depends on scmd_pkg (parse_t, keyword tables, character codes).
module scmd_parse (
	input  scmd_pkg::parse_t base,
	input  logic [7:0]       rx_byte,
	output scmd_pkg::parse_t nxt
);

	always_comb begin
		nxt = base;
		if (!base.text_ended) begin
			if (rx_byte == scmd_pkg::CH_NUL) begin
				nxt.text_ended = 1'b1;
			end else if (rx_byte == scmd_pkg::CH_SPACE) begin
				if (base.phase == scmd_pkg::PH_FIRST)
					nxt.phase = scmd_pkg::PH_AFTER;
			end else begin
				case (base.phase)
					scmd_pkg::PH_BEFORE, scmd_pkg::PH_FIRST: begin
						nxt.phase = scmd_pkg::PH_FIRST;
						if (base.kw_pos >= 3'(scmd_pkg::KW_MAX_LEN)) begin
							nxt.too_long = 1'b1;
						end else begin
							for (int k = 0; k < 8; k++) begin
								if (base.kw_pos >= scmd_pkg::kw_len(3'(k)) ||
										scmd_pkg::kw_char(3'(k), base.kw_pos) != rx_byte)
									nxt.kw_live[k] = 1'b0;
							end
							nxt.kw_pos = base.kw_pos + 3'd1;
						end
					end
					scmd_pkg::PH_AFTER: begin
						nxt.phase   = scmd_pkg::PH_ID;
						nxt.id_char = rx_byte;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// File: rtl/serial_command_motor_driver.sv
// serial_command_motor_driver: serial command line parser and two-motor pin/duty driver.
// Depends on scmd_pkg and scmd_parse.
// One received byte is taken per clock while in_stall is low; its result beat is registered into the
// output register, or into the second buffer entry while the output is held. Each byte goes through
// the token tracker and, on newline, the command executor with its saturating pulse add, all
// between the byte and the result register. A two-entry output buffer lets one more byte in
// while a result is held up; in_stall rises only when both entries are full. Nothing needs
// clearing after reset, and configuration writes take effect on the next byte.
module serial_command_motor_driver #(
	parameter int LINE_CAPACITY = scmd_pkg::LINE_CAPACITY
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       motor_a_sig1,
	output logic       motor_a_sig2,
	output logic       motor_b_sig1,
	output logic       motor_b_sig2,
	output logic [9:0] motor_a_duty,
	output logic [9:0] motor_b_duty,
	output logic [3:0] command_code
);

	localparam int MC    = scmd_pkg::MOTOR_COUNT;
	localparam int PW    = scmd_pkg::PULSE_W;
	localparam int LEN_W = $clog2(LINE_CAPACITY);
	localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAPACITY - 1);

	typedef struct packed {
		logic [3:0]     pins;
		logic [9:0]     duty_a;
		logic [9:0]     duty_b;
		scmd_pkg::cmd_t code;
	} res_t;

	function automatic logic signed [PW-1:0] clamp_pulse(input logic signed [PW:0] p,
			input logic [9:0] lim);
		logic signed [PW:0] l;
		logic signed [PW:0] r;
		l = $signed({2'b00, lim});
		if (p > l)
			r = l;
		else if (p < -l)
			r = -l;
		else
			r = p;
		return r[PW-1:0];
	endfunction

	function automatic logic [9:0] mag(input logic signed [PW-1:0] p);
		logic [PW-1:0] a;
		a = p[PW-1] ? PW'(-p) : PW'(p);
		return a[9:0];
	endfunction

	logic [9:0]              step_q, limit_q, cruise_q;
	logic [LEN_W-1:0]        line_len_q;
	scmd_pkg::parse_t        parse_q, saved_q, parse_base, parse_nxt;
	logic signed [PW-1:0]    pulse_q [MC];
	logic signed [PW-1:0]    pulse_nxt [MC];
	logic [3:0]              pins_q, pins_nxt;
	res_t                    out_q, skid_q, res_new;
	logic                    out_valid_q, skid_valid_q;

	logic                    acc, take, is_nl, is_cr, room;
	scmd_pkg::cmd_t          code;
	logic [MC-1:0]           upd, pset;
	logic [1:0]              pmode [MC];
	logic signed [PW:0]      tgt [MC];
	logic signed [PW:0]      step12, cr12;

	assign acc   = in_valid && !in_stall;
	assign take  = out_valid_q && !out_stall;
	assign is_nl = (rx_byte == scmd_pkg::CH_NL);
	assign is_cr = (rx_byte == scmd_pkg::CH_CR);
	assign room  = (line_len_q < LEN_LAST);

	// a full line rebuilds from the state before its last byte, which is then replaced
	assign parse_base = room ? parse_q : saved_q;

	scmd_parse u_parse (
		.base    (parse_base),
		.rx_byte (rx_byte),
		.nxt     (parse_nxt)
	);

	assign step12 = $signed({2'b00, step_q});
	assign cr12   = $signed({2'b00, cruise_q});

	// command executor, acts on the parse state of the line that newline closes
	always_comb begin
		code = scmd_pkg::CMD_NONE;
		for (int i = 0; i < MC; i++) begin
			upd[i]   = 1'b0;
			pset[i]  = 1'b0;
			pmode[i] = scmd_pkg::PINS_BRAKE;
			tgt[i]   = '0;
		end
		if (is_nl) begin
			if (parse_q.phase == scmd_pkg::PH_ID) begin
				for (int i = 0; i < MC; i++) begin
					if (parse_q.id_char == scmd_pkg::CH_ONE + 8'(i)) begin
						if (scmd_pkg::word_is(parse_q, scmd_pkg::KW_ON)) begin
							pset[i]  = 1'b1;
							pmode[i] = scmd_pkg::PINS_COAST;
							code     = scmd_pkg::CMD_ON;
						end else if (scmd_pkg::word_is(parse_q, scmd_pkg::KW_OFF)) begin
							pset[i]  = 1'b1;
							pmode[i] = scmd_pkg::PINS_BRAKE;
							code     = scmd_pkg::CMD_OFF;
						end else if (scmd_pkg::word_is(parse_q, scmd_pkg::KW_UP)) begin
							upd[i] = 1'b1;
							tgt[i] = $signed({pulse_q[i][PW-1], pulse_q[i]}) + step12;
							code   = scmd_pkg::CMD_UP;
						end else if (scmd_pkg::word_is(parse_q, scmd_pkg::KW_DOWN)) begin
							upd[i] = 1'b1;
							tgt[i] = $signed({pulse_q[i][PW-1], pulse_q[i]}) - step12;
							code   = scmd_pkg::CMD_DOWN;
						end
					end
				end
			end else if (parse_q.phase == scmd_pkg::PH_FIRST ||
					parse_q.phase == scmd_pkg::PH_AFTER) begin
				if (scmd_pkg::word_is(parse_q, scmd_pkg::KW_STOP)) begin
					pset     = '1;
					pmode[0] = scmd_pkg::PINS_COAST;
					pmode[1] = scmd_pkg::PINS_COAST;
					code     = scmd_pkg::CMD_STOP;
				end else if (scmd_pkg::word_is(parse_q, scmd_pkg::KW_START)) begin
					upd    = '1;
					tgt[0] = cr12;
					tgt[1] = cr12;
					code   = scmd_pkg::CMD_START;
				end else if (scmd_pkg::word_is(parse_q, scmd_pkg::KW_LEFT)) begin
					upd    = '1;
					tgt[0] = -cr12;
					tgt[1] = cr12;
					code   = scmd_pkg::CMD_LEFT;
				end else if (scmd_pkg::word_is(parse_q, scmd_pkg::KW_RIGHT)) begin
					upd    = '1;
					tgt[0] = cr12;
					tgt[1] = -cr12;
					code   = scmd_pkg::CMD_RIGHT;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MC; i++) begin
			pulse_nxt[i] = upd[i] ? clamp_pulse(tgt[i], limit_q) : pulse_q[i];
			if (upd[i])
				pins_nxt[2*i +: 2] = (pulse_nxt[i] > 0) ? scmd_pkg::PINS_FWD : scmd_pkg::PINS_REV;
			else if (pset[i])
				pins_nxt[2*i +: 2] = pmode[i];
			else
				pins_nxt[2*i +: 2] = pins_q[2*i +: 2];
		end
	end

	assign res_new = '{
		pins:   pins_nxt,
		duty_a: mag(pulse_nxt[0]),
		duty_b: mag(pulse_nxt[1]),
		code:   code
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= scmd_pkg::STEP_SIZE_RST;
			limit_q  <= scmd_pkg::DUTY_LIMIT_RST;
			cruise_q <= scmd_pkg::CRUISE_DUTY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				scmd_pkg::CFG_STEP_SIZE:   step_q   <= cfg_data;
				scmd_pkg::CFG_DUTY_LIMIT:  limit_q  <= cfg_data;
				scmd_pkg::CFG_CRUISE_DUTY: cruise_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			parse_q    <= scmd_pkg::PARSE_CLEAR;
			saved_q    <= scmd_pkg::parse_t'('0);
			pins_q     <= '0;
			for (int i = 0; i < MC; i++)
				pulse_q[i] <= '0;
		end else if (acc) begin
			pins_q <= pins_nxt;
			for (int i = 0; i < MC; i++)
				pulse_q[i] <= pulse_nxt[i];
			if (is_nl) begin
				line_len_q <= '0;
				parse_q    <= scmd_pkg::PARSE_CLEAR;
				saved_q    <= scmd_pkg::parse_t'('0);
			end else if (!is_cr) begin
				if (room) begin
					saved_q    <= parse_q;
					line_len_q <= line_len_q + 1'b1;
				end
				parse_q <= parse_nxt;
			end
		end
	end

	// two-entry result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (acc) begin
			if (!out_valid_q || take)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (take) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (!out_valid_q || take)
				out_q <= res_new;
			else
				skid_q <= res_new;
		end else if (take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign in_stall     = skid_valid_q;
	assign out_valid    = out_valid_q;
	assign motor_a_sig1 = out_q.pins[0];
	assign motor_a_sig2 = out_q.pins[1];
	assign motor_b_sig1 = out_q.pins[2];
	assign motor_b_sig2 = out_q.pins[3];
	assign motor_a_duty = out_q.duty_a;
	assign motor_b_duty = out_q.duty_b;
	assign command_code = out_q.code;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("result buffer second entry held without first");

	a_line_len: assert property (@(posedge clk) disable iff (!arst_n)
		line_len_q <= LEN_LAST)
		else $error("line length past capacity");

	a_newline_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_nl) |=> (line_len_q == '0 && parse_q == scmd_pkg::PARSE_CLEAR))
		else $error("newline did not clear the line");

	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_q[0] != $signed(11'h400) && pulse_q[1] != $signed(11'h400))
		else $error("pulse outside saturation range");

	a_kw_pos: assert property (@(posedge clk) disable iff (!arst_n)
		parse_q.kw_pos <= 3'(scmd_pkg::KW_MAX_LEN))
		else $error("keyword position past longest keyword");

endmodule
